// ===== design/sdrd_pkg.sv =====
// shared types and constants for the sd spi block read receiver
package sdrd_pkg;

    localparam int BLOCK_BYTES = 512;
    localparam int CNT_W       = $clog2(BLOCK_BYTES);
    localparam int MAX_RESULTS = 6;
    localparam int QCNT_W      = $clog2(MAX_RESULTS + 1);
    localparam int CRC7_MSG_W  = 40;

    localparam logic [7:0]  OP_READ_SINGLE = 8'h51;
    localparam logic [7:0]  OP_READ_MULTI  = 8'h52;
    localparam logic [7:0]  TOKEN_START    = 8'hFE;
    localparam logic [7:0]  TOKEN_ERR_MASK = 8'hF0;
    localparam logic [7:0]  RESP_BUSY_MASK = 8'h80;
    localparam logic [6:0]  CRC7_POLY      = 7'h09;
    localparam logic [15:0] CRC16_POLY     = 16'h1021;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_BYTE  = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RESP,
        PH_TOKEN,
        PH_DATA,
        PH_CRC_HI,
        PH_CRC_LO
    } t_phase;

    typedef enum logic [2:0] {
        KIND_CMD    = 3'd0,
        KIND_DATA   = 3'd1,
        KIND_CRC_OK = 3'd2,
        KIND_ERROR  = 3'd3,
        KIND_FINISH = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_TOKEN = 2'd1,
        ERR_CRC   = 2'd2
    } t_err;

    typedef struct packed {
        logic        command;
        logic [31:0] block_address;
        logic [15:0] block_count;
        logic [7:0]  rx_byte;
    } t_item;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  value;
        logic [8:0]  byte_offset;
        logic [15:0] block_number;
        t_err        error_code;
        logic        transfer_done;
        logic        needs_stop;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [QCNT_W-1:0]                 cnt;
        t_result [MAX_RESULTS-1:0]         res;
    } t_bundle;

endpackage

// ===== design/sdrd_core.sv =====
// transfer state and per-item result bundle for the block read receiver
module sdrd_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  sdrd_pkg::t_item   i_item,
    output sdrd_pkg::t_bundle o_bundle
);

    typedef logic [sdrd_pkg::CRC7_MSG_W-1:0][6:0] t_crc7_cols;

    // crc7 is linear: one syndrome column per message bit
    function automatic t_crc7_cols crc7_columns();
        t_crc7_cols cols;
        logic [6:0] c;
        logic       fb;
        for (int j = 0; j < sdrd_pkg::CRC7_MSG_W; j++) begin
            c = '0;
            for (int i = sdrd_pkg::CRC7_MSG_W - 1; i >= 0; i--) begin
                fb = c[6] ^ (i == j);
                c  = {c[5:0], 1'b0} ^ (fb ? sdrd_pkg::CRC7_POLY : 7'h00);
            end
            cols[j] = c;
        end
        return cols;
    endfunction

    localparam t_crc7_cols CRC7_COLS = crc7_columns();

    function automatic logic [6:0] crc7_msg(input logic [sdrd_pkg::CRC7_MSG_W-1:0] msg);
        logic [6:0] c;
        c = '0;
        for (int j = 0; j < sdrd_pkg::CRC7_MSG_W; j++) begin
            c = c ^ (msg[j] ? CRC7_COLS[j] : 7'h00);
        end
        return c;
    endfunction

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ sdrd_pkg::CRC16_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic sdrd_pkg::t_result mk_res(
        input sdrd_pkg::t_kind kind,
        input logic [7:0]      value,
        input logic [8:0]      offset,
        input logic [15:0]     blk,
        input sdrd_pkg::t_err  err,
        input logic            done,
        input logic            stop,
        input logic            last
    );
        sdrd_pkg::t_result r;
        r.kind          = kind;
        r.value         = value;
        r.byte_offset   = offset;
        r.block_number  = blk;
        r.error_code    = err;
        r.transfer_done = done;
        r.needs_stop    = stop;
        r.last          = last;
        return r;
    endfunction

    localparam logic [sdrd_pkg::CNT_W-1:0] LAST_BYTE = sdrd_pkg::CNT_W'(sdrd_pkg::BLOCK_BYTES - 1);

    sdrd_pkg::t_phase              r_phase, n_phase;
    logic [sdrd_pkg::CNT_W-1:0]    r_byte_cnt, n_byte_cnt;
    logic [15:0]                   r_cur_blk, n_cur_blk;
    logic [15:0]                   r_total, n_total;
    logic [15:0]                   r_crc, n_crc;
    logic [7:0]                    r_crc_hi, n_crc_hi;

    logic [7:0]                    frame_op;
    logic [sdrd_pkg::CRC7_MSG_W-1:0] frame_msg;
    logic [6:0]                    frame_crc;
    logic [sdrd_pkg::CNT_W+8:0]    offset_ext;
    logic [15:0]                   blk_inc;
    logic [7:0]                    b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= sdrd_pkg::PH_IDLE;
            r_byte_cnt <= '0;
            r_cur_blk  <= '0;
            r_total    <= '0;
            r_crc      <= '0;
            r_crc_hi   <= '0;
        end else if (i_advance) begin
            r_phase    <= n_phase;
            r_byte_cnt <= n_byte_cnt;
            r_cur_blk  <= n_cur_blk;
            r_total    <= n_total;
            r_crc      <= n_crc;
            r_crc_hi   <= n_crc_hi;
        end
    end

    always_comb begin
        b          = i_item.rx_byte;
        frame_op   = (i_item.block_count == 16'd1) ? sdrd_pkg::OP_READ_SINGLE
                                                   : sdrd_pkg::OP_READ_MULTI;
        frame_msg  = {frame_op, i_item.block_address};
        frame_crc  = crc7_msg(frame_msg);
        offset_ext = {9'b0, r_byte_cnt};
        blk_inc    = r_cur_blk + 16'd1;

        n_phase    = r_phase;
        n_byte_cnt = r_byte_cnt;
        n_cur_blk  = r_cur_blk;
        n_total    = r_total;
        n_crc      = r_crc;
        n_crc_hi   = r_crc_hi;
        o_bundle   = '0;

        if (i_item.command == sdrd_pkg::CMD_START) begin
            n_byte_cnt = '0;
            n_cur_blk  = '0;
            n_crc      = '0;
            n_crc_hi   = '0;
            n_total    = i_item.block_count;
            if (i_item.block_count == 16'd0) begin
                n_phase         = sdrd_pkg::PH_IDLE;
                o_bundle.cnt    = sdrd_pkg::QCNT_W'(1);
                o_bundle.res[0] = mk_res(sdrd_pkg::KIND_FINISH, 8'h00, 9'd0, 16'd0,
                                         sdrd_pkg::ERR_NONE, 1'b1, 1'b0, 1'b1);
            end else begin
                n_phase         = sdrd_pkg::PH_RESP;
                o_bundle.cnt    = sdrd_pkg::QCNT_W'(sdrd_pkg::MAX_RESULTS);
                o_bundle.res[0] = mk_res(sdrd_pkg::KIND_CMD, frame_op, 9'd0, 16'd0,
                                         sdrd_pkg::ERR_NONE, 1'b0, 1'b0, 1'b0);
                o_bundle.res[1] = mk_res(sdrd_pkg::KIND_CMD, i_item.block_address[31:24],
                                         9'd0, 16'd0, sdrd_pkg::ERR_NONE, 1'b0, 1'b0, 1'b0);
                o_bundle.res[2] = mk_res(sdrd_pkg::KIND_CMD, i_item.block_address[23:16],
                                         9'd0, 16'd0, sdrd_pkg::ERR_NONE, 1'b0, 1'b0, 1'b0);
                o_bundle.res[3] = mk_res(sdrd_pkg::KIND_CMD, i_item.block_address[15:8],
                                         9'd0, 16'd0, sdrd_pkg::ERR_NONE, 1'b0, 1'b0, 1'b0);
                o_bundle.res[4] = mk_res(sdrd_pkg::KIND_CMD, i_item.block_address[7:0],
                                         9'd0, 16'd0, sdrd_pkg::ERR_NONE, 1'b0, 1'b0, 1'b0);
                o_bundle.res[5] = mk_res(sdrd_pkg::KIND_CMD, {frame_crc, 1'b1},
                                         9'd0, 16'd0, sdrd_pkg::ERR_NONE, 1'b0, 1'b0, 1'b1);
            end
        end else begin
            unique case (r_phase)
                sdrd_pkg::PH_RESP: begin
                    if ((b & sdrd_pkg::RESP_BUSY_MASK) == 8'h00) begin
                        n_phase = sdrd_pkg::PH_TOKEN;
                    end
                end
                sdrd_pkg::PH_TOKEN: begin
                    if (b == sdrd_pkg::TOKEN_START) begin
                        n_phase    = sdrd_pkg::PH_DATA;
                        n_byte_cnt = '0;
                        n_crc      = '0;
                    end else if ((b & sdrd_pkg::TOKEN_ERR_MASK) == 8'h00) begin
                        n_phase         = sdrd_pkg::PH_IDLE;
                        o_bundle.cnt    = sdrd_pkg::QCNT_W'(1);
                        o_bundle.res[0] = mk_res(sdrd_pkg::KIND_ERROR, b, 9'd0, r_cur_blk,
                                                 sdrd_pkg::ERR_TOKEN, 1'b0, 1'b0, 1'b1);
                    end
                end
                sdrd_pkg::PH_DATA: begin
                    o_bundle.cnt    = sdrd_pkg::QCNT_W'(1);
                    o_bundle.res[0] = mk_res(sdrd_pkg::KIND_DATA, b, offset_ext[8:0], r_cur_blk,
                                             sdrd_pkg::ERR_NONE, 1'b0, 1'b0, 1'b1);
                    n_crc = crc16_byte(r_crc, b);
                    if (r_byte_cnt == LAST_BYTE) begin
                        n_byte_cnt = '0;
                        n_phase    = sdrd_pkg::PH_CRC_HI;
                    end else begin
                        n_byte_cnt = r_byte_cnt + 1'b1;
                    end
                end
                sdrd_pkg::PH_CRC_HI: begin
                    n_crc_hi = b;
                    n_phase  = sdrd_pkg::PH_CRC_LO;
                end
                sdrd_pkg::PH_CRC_LO: begin
                    o_bundle.cnt = sdrd_pkg::QCNT_W'(1);
                    if ({r_crc_hi, b} != r_crc) begin
                        n_phase         = sdrd_pkg::PH_IDLE;
                        o_bundle.res[0] = mk_res(sdrd_pkg::KIND_ERROR, 8'h00, 9'd0, r_cur_blk,
                                                 sdrd_pkg::ERR_CRC, 1'b0, 1'b0, 1'b1);
                    end else begin
                        n_cur_blk = blk_inc;
                        if (blk_inc == r_total) begin
                            n_phase         = sdrd_pkg::PH_IDLE;
                            o_bundle.cnt    = sdrd_pkg::QCNT_W'(2);
                            o_bundle.res[0] = mk_res(sdrd_pkg::KIND_CRC_OK, 8'h00, 9'd0,
                                                     r_cur_blk, sdrd_pkg::ERR_NONE,
                                                     1'b1, 1'b0, 1'b0);
                            o_bundle.res[1] = mk_res(sdrd_pkg::KIND_FINISH, 8'h00, 9'd0, 16'd0,
                                                     sdrd_pkg::ERR_NONE, 1'b1,
                                                     (r_total > 16'd1), 1'b1);
                        end else begin
                            n_phase         = sdrd_pkg::PH_TOKEN;
                            o_bundle.res[0] = mk_res(sdrd_pkg::KIND_CRC_OK, 8'h00, 9'd0,
                                                     r_cur_blk, sdrd_pkg::ERR_NONE,
                                                     1'b0, 1'b0, 1'b1);
                        end
                    end
                end
                default: begin
                    // idle: received bytes are dropped
                end
            endcase
        end
    end

endmodule

// ===== design/sdrd_outq.sv =====
// result queue: loads one bundle and shifts it out one beat at a time
module sdrd_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  sdrd_pkg::t_bundle i_bundle,
    input  logic              i_ready,
    output logic              o_valid,
    output sdrd_pkg::t_result o_head,
    output logic              o_free
);

    logic [sdrd_pkg::QCNT_W-1:0]              r_cnt;
    sdrd_pkg::t_result [sdrd_pkg::MAX_RESULTS-1:0] r_q;
    logic                                     beat;

    assign o_valid = (r_cnt != '0);
    assign o_head  = r_q[0];
    assign beat    = o_valid && i_ready;
    // free when empty or when the final entry leaves this cycle
    assign o_free  = (r_cnt == '0) || ((r_cnt == sdrd_pkg::QCNT_W'(1)) && i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_bundle.cnt;
        end else if (beat) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_q <= i_bundle.res;
        end else if (beat) begin
            for (int i = 0; i < sdrd_pkg::MAX_RESULTS - 1; i++) begin
                r_q[i] <= r_q[i+1];
            end
        end
    end

endmodule

// ===== design/sd_spi_block_read_receiver_unit.sv =====
// top level of the sd spi mode block read receiver
//
// input channel (i_in_valid / o_in_ready): one item per beat, either a start
// (i_command 0, with block address and count) or one byte received from the
// card (i_command 1, i_rx_byte). output channel (o_out_valid / i_out_ready):
// one result per beat, o_last marks the final result of an item.
// a start emits the six command bytes (single or multi block read with crc7),
// or one finished result when the count is zero. bytes are scanned for the
// response, the start or error token, the data bytes and the crc16 pair.
// an accepted item is held in the input register until the queue is free,
// then processed by the core, and its results are registered into the queue.
// throughput: one item per cycle while results drain as fast as they come;
// a start puts six results into the result queue, a last-block crc two.
// the six-entry result queue sets the rate: a new item is processed only when
// the queue is empty or its final entry leaves in the same cycle.
// if the receiver stalls, results wait in the queue, the input register fills
// and o_in_ready drops; nothing is lost or repeated.
// reset (synchronous, active low) empties the queue and input register and
// returns the transfer to idle with all counters and the crc cleared.
module sd_spi_block_read_receiver_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [31:0] i_block_address,
    input  logic [15:0] i_block_count,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_value,
    output logic [8:0]  o_byte_offset,
    output logic [15:0] o_block_number,
    output logic [1:0]  o_error_code,
    output logic        o_transfer_done,
    output logic        o_needs_stop,
    output logic        o_last
);

    // input register
    logic              r_in_valid;
    sdrd_pkg::t_item   r_in;
    logic              advance;
    logic              q_free;
    sdrd_pkg::t_bundle bundle;
    sdrd_pkg::t_result head;

    // item moves into the core once the queue can take its results
    assign advance    = r_in_valid && q_free;
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in.command       <= i_command;
            r_in.block_address <= i_block_address;
            r_in.block_count   <= i_block_count;
            r_in.rx_byte       <= i_rx_byte;
        end
    end

    sdrd_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in),
        .o_bundle  (bundle)
    );

    sdrd_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_bundle (bundle),
        .i_ready  (i_out_ready),
        .o_valid  (o_out_valid),
        .o_head   (head),
        .o_free   (q_free)
    );

    // result beat fields
    assign o_kind          = head.kind;
    assign o_value         = head.value;
    assign o_byte_offset   = head.byte_offset;
    assign o_block_number  = head.block_number;
    assign o_error_code    = head.error_code;
    assign o_transfer_done = head.transfer_done;
    assign o_needs_stop    = head.needs_stop;
    assign o_last          = head.last;

    // a start with blocks to read presents the command opcode next
    a_start_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_in.command == sdrd_pkg::CMD_START) && (r_in.block_count != 16'd0)
        |=> o_out_valid && (o_kind == sdrd_pkg::KIND_CMD) && !o_last)
        else $error("start did not present a command byte");

    // a zero-count start gives a lone finished result
    a_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_in.command == sdrd_pkg::CMD_START) && (r_in.block_count == 16'd0)
        |=> o_out_valid && (o_kind == sdrd_pkg::KIND_FINISH) && o_last && o_transfer_done)
        else $error("zero-count start did not finish at once");

    // stop request only rides on a finished result
    a_stop_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_needs_stop
        |-> (o_kind == sdrd_pkg::KIND_FINISH) && o_transfer_done)
        else $error("needs_stop on a result that is not finished");

    // data beats never carry an error or done flag
    a_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == sdrd_pkg::KIND_DATA)
        |-> (o_error_code == sdrd_pkg::ERR_NONE) && !o_transfer_done && o_last)
        else $error("data beat carries status");

endmodule
